// ===== hdl/audio_ring_buffer_overrun_underrun_core_assert.svh =====
// Assertion macros used by the audio ring buffer back end.
// Build with ASSERT_OFF defined to drop every check.
`ifndef AUDIO_RING_BUFFER_OVERRUN_UNDERRUN_CORE_ASSERT_SVH
`define AUDIO_RING_BUFFER_OVERRUN_UNDERRUN_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ARBRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define ARBRC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ARBRC_ASSERT(lbl, clk, rst_n, prop)
`define ARBRC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hdl/arbrc_pkg.sv =====
`timescale 1ns / 1ps

package arbrc_pkg;

  // Packet and Depth are powers of two; Depth is a multiple of Packet
  localparam int unsigned Packet   = 64;
  localparam int unsigned Depth    = 16384;

  localparam int unsigned PktW     = $clog2(Packet);
  localparam int unsigned PktCntW  = $clog2(Packet + 1);
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned SizeW    = $clog2(Depth + 1);
  localparam int unsigned CfgW     = 15;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned DropW    = 15;
  localparam int unsigned CmdDepth = 4;

  localparam logic [CfgW-1:0] SizeReset   = CfgW'(11520);
  localparam logic [CfgW-1:0] RefillReset = CfgW'(5760);

  // Configuration register indexes
  typedef enum logic {
    RegSize   = 1'b0,
    RegRefill = 1'b1
  } cfg_reg_e;

  // Command classes handed from the front end to the back end
  typedef enum logic [1:0] {
    OpSample = 2'd0,
    OpCommit = 2'd1,
    OpRead   = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                    op;
    logic [PktW-1:0]            slot;
    logic signed [SampleW-1:0]  left;
    logic signed [SampleW-1:0]  right;
  } cmd_t;

  typedef struct packed {
    logic [CfgW-1:0] size;
    logic [CfgW-1:0] refill;
  } cfg_t;

endpackage

// ===== hdl/audio_ring_buffer_overrun_underrun_core.sv =====
`timescale 1ns / 1ps
// Channel  Signals                                        Direction
// -------  ---------------------------------------------  ---------------
// in       in_valid_i / in_stall_o, action_i, samples     request in
// out      out_valid_o / out_stall_i, kind_o ... last_o   result out
// cfg      cfg_we_i, cfg_index_i, cfg_wdata_i             register write
//
// A sample write is staged by the back end; a packet commit runs an overrun
// check, an optional overrun event and the staging-to-ring copy.
// A read request emits Packet results at up to one per cycle while the output
// buffer has room, through the registered ring memory read port.
// A register write triggers a pointer reduction pass before the next
// request; reset clears control state only, no memory clearing pass.
// A four-entry command queue keeps accepting requests while the back end
// works; a two-entry output buffer absorbs downstream stalls.

module audio_ring_buffer_overrun_underrun_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic signed [arbrc_pkg::SampleW-1:0] sample_left_i,
  input  logic signed [arbrc_pkg::SampleW-1:0] sample_right_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           kind_o,
  output logic signed [arbrc_pkg::SampleW-1:0] out_left_o,
  output logic signed [arbrc_pkg::SampleW-1:0] out_right_o,
  output logic [arbrc_pkg::DropW-1:0]          dropped_count_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [arbrc_pkg::CfgW-1:0]           cfg_wdata_i
);

  arbrc_pkg::cfg_t cfg_q;
  arbrc_pkg::cmd_t front_cmd, queue_cmd;
  logic            q_push, q_full, q_valid, q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size   <= arbrc_pkg::SizeReset;
      cfg_q.refill <= arbrc_pkg::RefillReset;
    end else if (cfg_we_i) begin
      unique case (arbrc_pkg::cfg_reg_e'(cfg_index_i))
        arbrc_pkg::RegSize:   cfg_q.size   <= cfg_wdata_i;
        arbrc_pkg::RegRefill: cfg_q.refill <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  arbrc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (front_cmd)
  );

  arbrc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  arbrc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cfg_wr_i        (cfg_we_i),
    .cmd_valid_i     (q_valid),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .dropped_count_o (dropped_count_o),
    .last_o          (last_o)
  );

endmodule

// ===== hdl/arbrc_front.sv =====
`timescale 1ns / 1ps

module arbrc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic signed [arbrc_pkg::SampleW-1:0] sample_left_i,
  input  logic signed [arbrc_pkg::SampleW-1:0] sample_right_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output arbrc_pkg::cmd_t                      q_cmd_o
);

  localparam int unsigned PktW = arbrc_pkg::PktW;
  localparam logic [PktW-1:0] LastSlot = PktW'(arbrc_pkg::Packet - 1);

  logic [PktW-1:0] slot_q, slot_d;
  logic            accept;

  // Requests pass straight into the command queue
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Classify: a read, a staged sample, or the sample that completes a packet
  always_comb begin
    q_cmd_o.slot  = slot_q;
    q_cmd_o.left  = sample_left_i;
    q_cmd_o.right = sample_right_i;
    if (action_i) begin
      q_cmd_o.op = arbrc_pkg::OpRead;
    end else if (slot_q == LastSlot) begin
      q_cmd_o.op = arbrc_pkg::OpCommit;
    end else begin
      q_cmd_o.op = arbrc_pkg::OpSample;
    end

    slot_d = slot_q;
    if (accept && !action_i) begin
      slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== hdl/arbrc_cmd_fifo.sv =====
`timescale 1ns / 1ps

module arbrc_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  arbrc_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output arbrc_pkg::cmd_t cmd_o
);

  localparam int unsigned Entries = arbrc_pkg::CmdDepth;
  localparam int unsigned PtrW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);

  arbrc_pkg::cmd_t mem_q [Entries];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Entries));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and count bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Entries - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Entries - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/arbrc_back.sv =====
`timescale 1ns / 1ps
`include "audio_ring_buffer_overrun_underrun_core_assert.svh"

module arbrc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  arbrc_pkg::cfg_t                      cfg_i,
  input  logic                                 cfg_wr_i,
  input  logic                                 cmd_valid_i,
  input  arbrc_pkg::cmd_t                      cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           kind_o,
  output logic signed [arbrc_pkg::SampleW-1:0] out_left_o,
  output logic signed [arbrc_pkg::SampleW-1:0] out_right_o,
  output logic [arbrc_pkg::DropW-1:0]          dropped_count_o,
  output logic                                 last_o
);

  localparam int unsigned Packet    = arbrc_pkg::Packet;
  localparam int unsigned Depth     = arbrc_pkg::Depth;
  localparam int unsigned PktW      = arbrc_pkg::PktW;
  localparam int unsigned PktCntW   = arbrc_pkg::PktCntW;
  localparam int unsigned AddrW     = arbrc_pkg::AddrW;
  localparam int unsigned SizeW     = arbrc_pkg::SizeW;
  localparam int unsigned CfgW      = arbrc_pkg::CfgW;
  localparam int unsigned SampleW   = arbrc_pkg::SampleW;
  localparam int unsigned DropW     = arbrc_pkg::DropW;
  localparam int unsigned SumW      = SizeW + 1;
  localparam int unsigned WideW     = ((CfgW > SizeW) ? CfgW : SizeW) + 1;
  localparam int unsigned NormSteps = $clog2(Depth / Packet);
  localparam int unsigned NormStepW = $clog2(NormSteps);
  localparam int unsigned NormW     = AddrW + NormSteps;
  localparam int unsigned OutDepth  = 2;
  localparam int unsigned OutCntW   = 2;
  localparam int unsigned OccW      = OutCntW + 1;
  localparam int unsigned WordW     = 2 * SampleW;

  typedef enum logic [2:0] {
    StIdle,
    StNorm,
    StOvrCalc,
    StOvrEmit,
    StCopy,
    StRead
  } state_e;

  typedef enum logic [1:0] {
    KindBuffered = 2'd0,
    KindSilence  = 2'd1,
    KindOverrun  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             from_mem;
    logic [DropW-1:0] drop;
    logic             last;
  } issue_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic [DropW-1:0]          drop;
    logic                      last;
  } result_t;

  // Effective ring size: round down to a packet, clamp to [Packet, Depth]
  function automatic logic [SizeW-1:0] eff_size(input logic [CfgW-1:0] raw);
    logic [WideW-1:0] s;
    s = WideW'(raw) & ~WideW'(Packet - 1);
    if (s < WideW'(Packet)) s = WideW'(Packet);
    if (s > WideW'(Depth)) s = WideW'(Depth);
    return SizeW'(s);
  endfunction

  // Freeze exit level: round up to a packet, clamp to [Packet, size]
  function automatic logic [SizeW-1:0] refill_target(input logic [CfgW-1:0]  raw,
                                                     input logic [SizeW-1:0] sz);
    logic [WideW-1:0] t;
    t = (WideW'(raw) + WideW'(Packet - 1)) & ~WideW'(Packet - 1);
    if (t < WideW'(Packet)) t = WideW'(Packet);
    if (t > WideW'(sz)) t = WideW'(sz);
    return SizeW'(t);
  endfunction

  state_e                 state_q, state_d;
  logic                   norm_pend_q, norm_pend_d;
  logic [NormStepW-1:0]   norm_step_q, norm_step_d;
  logic [AddrW-1:0]       rp_q, rp_d, wp_q, wp_d;
  logic [SizeW-1:0]       fill_q, fill_d;
  logic                   freeze_q, freeze_d;
  logic [SizeW-1:0]       comp_q, comp_d;
  logic                   ovr_q, ovr_d;
  logic [PktCntW-1:0]     cnt_q, cnt_d;
  logic [PktCntW-1:0]     avail_q, avail_d;
  logic                   iss_valid_q, iss_valid_d;
  issue_t                 iss_q, iss_d;
  logic [OutCntW-1:0]     ocnt_q, ocnt_d;
  logic                   owr_q, owr_d, ord_q, ord_d;

  logic [SizeW-1:0]       size, to_fill;
  logic [AddrW-1:0]       rp_inc, wp_inc, rp_adv;
  logic [SumW-1:0]        rp_sum;
  logic [SumW-1:0]        half, align;
  logic [SizeW-1:0]       cap, need, c1, c2, comp_calc;
  logic                   ovr_calc;
  logic [NormW-1:0]       sz_sh, rp_ext, wp_ext;
  logic [PktCntW-1:0]     rd_avail;
  logic                   rd_freeze;
  logic [OccW-1:0]        occ;
  logic                   issue_ok, out_pop;

  logic                   stg_we, stg_re, ring_we, ring_re;
  logic [PktW-1:0]        stg_raddr;
  logic [WordW-1:0]       stg_mem [Packet];
  logic [WordW-1:0]       stg_rdata_q;
  logic [WordW-1:0]       ring_mem [Depth];
  logic [WordW-1:0]       ring_rdata_q;

  result_t                ofifo_q [OutDepth];
  result_t                push_data, head;

  assign size    = eff_size(cfg_i.size);
  assign to_fill = refill_target(cfg_i.refill, size);

  // Pointer stepping with wrap at the ring size
  assign rp_inc = ((SizeW'(rp_q) + SizeW'(1)) >= size) ? '0 : rp_q + 1'b1;
  assign wp_inc = ((SizeW'(wp_q) + SizeW'(1)) >= size) ? '0 : wp_q + 1'b1;
  assign rp_sum = SumW'(rp_q) + SumW'(comp_q);
  assign rp_adv = (rp_sum >= SumW'(size)) ? AddrW'(rp_sum - SumW'(size)) : AddrW'(rp_sum);

  // Overrun drop: half the ring plus a packet, aligned up, capped, at least
  // enough for one packet to fit, never more than the fill
  assign ovr_calc  = (size - fill_q) < SizeW'(Packet);
  assign half      = (SumW'(size) + SumW'(Packet)) >> 1;
  assign align     = (half + SumW'(Packet - 1)) & ~SumW'(Packet - 1);
  assign cap       = size - SizeW'(Packet);
  assign need      = fill_q - cap;
  assign c1        = (align > SumW'(cap)) ? cap : SizeW'(align);
  assign c2        = (c1 < need) ? need : c1;
  assign comp_calc = (c2 > fill_q) ? fill_q : c2;

  // Restoring reduction of the pointers after a register write, one shift per step
  assign sz_sh  = NormW'(size) << norm_step_q;
  assign rp_ext = NormW'(rp_q);
  assign wp_ext = NormW'(wp_q);

  // Samples available to a read request, and the freeze flag it leaves
  always_comb begin
    rd_avail  = PktCntW'(Packet);
    rd_freeze = freeze_q;
    if (freeze_q) begin
      if (fill_q < to_fill) begin
        rd_avail = '0;
      end else begin
        rd_freeze = 1'b0;
      end
    end else if (fill_q < SizeW'(Packet)) begin
      rd_avail  = PktCntW'(fill_q);
      rd_freeze = 1'b1;
    end
  end

  // Issue only when the output buffer has room counting the result in flight
  assign out_pop  = out_valid_o && !out_stall_i;
  assign occ      = OccW'(ocnt_q) + OccW'(iss_valid_q);
  assign issue_ok = occ < (OccW'(OutDepth) + OccW'(out_pop));

  assign stg_raddr = cnt_q[PktW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    norm_pend_d = norm_pend_q;
    norm_step_d = norm_step_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    freeze_d    = freeze_q;
    comp_d      = comp_q;
    ovr_d       = ovr_q;
    cnt_d       = cnt_q;
    avail_d     = avail_q;
    iss_valid_d = 1'b0;
    iss_d       = iss_q;
    cmd_pop_o   = 1'b0;
    stg_we      = 1'b0;
    stg_re      = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (norm_pend_q) begin
          state_d     = StNorm;
          norm_step_d = NormStepW'(NormSteps - 1);
        end else if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            arbrc_pkg::OpSample: begin
              stg_we = 1'b1;
            end
            arbrc_pkg::OpCommit: begin
              stg_we  = 1'b1;
              state_d = StOvrCalc;
            end
            arbrc_pkg::OpRead: begin
              avail_d  = rd_avail;
              freeze_d = rd_freeze;
              fill_d   = fill_q - SizeW'(rd_avail);
              cnt_d    = '0;
              state_d  = StRead;
            end
            default: begin
            end
          endcase
        end
      end

      StNorm: begin
        if (rp_ext >= sz_sh) rp_d = AddrW'(rp_ext - sz_sh);
        if (wp_ext >= sz_sh) wp_d = AddrW'(wp_ext - sz_sh);
        if (norm_step_q == '0) begin
          if (fill_q > size) fill_d = size;
          norm_pend_d = 1'b0;
          state_d     = StIdle;
        end else begin
          norm_step_d = norm_step_q - 1'b1;
        end
      end

      StOvrCalc: begin
        ovr_d   = ovr_calc;
        comp_d  = comp_calc;
        state_d = StOvrEmit;
      end

      StOvrEmit: begin
        if (!ovr_q) begin
          cnt_d   = '0;
          state_d = StCopy;
        end else if (issue_ok) begin
          iss_valid_d = 1'b1;
          iss_d       = '{kind: KindOverrun, from_mem: 1'b0,
                          drop: DropW'(comp_q), last: 1'b1};
          fill_d      = fill_q - comp_q;
          rp_d        = rp_adv;
          cnt_d       = '0;
          state_d     = StCopy;
        end
      end

      // Each staging read is registered and written to the ring in the next cycle
      StCopy: begin
        if (cnt_q != PktCntW'(Packet)) stg_re = 1'b1;
        if (cnt_q != '0) begin
          ring_we = 1'b1;
          wp_d    = wp_inc;
        end
        if (cnt_q == PktCntW'(Packet)) begin
          fill_d  = fill_q + SizeW'(Packet);
          state_d = StIdle;
        end
        cnt_d = cnt_q + 1'b1;
      end

      StRead: begin
        if (issue_ok) begin
          iss_valid_d = 1'b1;
          iss_d.drop  = '0;
          iss_d.last  = (cnt_q == PktCntW'(Packet - 1));
          if (cnt_q < avail_q) begin
            ring_re        = 1'b1;
            iss_d.kind     = KindBuffered;
            iss_d.from_mem = 1'b1;
            rp_d           = rp_inc;
          end else begin
            iss_d.kind     = KindSilence;
            iss_d.from_mem = 1'b0;
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == PktCntW'(Packet - 1)) state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Any register write forces a fresh reduction pass
    if (cfg_wr_i) begin
      norm_pend_d = 1'b1;
      if (state_q == StNorm) norm_step_d = NormStepW'(NormSteps - 1);
    end
  end

  // Output buffer bookkeeping
  always_comb begin
    owr_d  = owr_q ^ iss_valid_q;
    ord_d  = ord_q ^ out_pop;
    ocnt_d = OutCntW'(ocnt_q + OutCntW'(iss_valid_q) - OutCntW'(out_pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      norm_pend_q <= 1'b0;
      norm_step_q <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      freeze_q    <= 1'b0;
      comp_q      <= '0;
      ovr_q       <= 1'b0;
      cnt_q       <= '0;
      avail_q     <= '0;
      iss_valid_q <= 1'b0;
      iss_q       <= '0;
      ocnt_q      <= '0;
      owr_q       <= 1'b0;
      ord_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      norm_pend_q <= norm_pend_d;
      norm_step_q <= norm_step_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      freeze_q    <= freeze_d;
      comp_q      <= comp_d;
      ovr_q       <= ovr_d;
      cnt_q       <= cnt_d;
      avail_q     <= avail_d;
      iss_valid_q <= iss_valid_d;
      iss_q       <= iss_d;
      ocnt_q      <= ocnt_d;
      owr_q       <= owr_d;
      ord_q       <= ord_d;
    end
  end

  // Staging packet memory
  always_ff @(posedge clk_i) begin
    if (stg_we) stg_mem[cmd_i.slot] <= {cmd_i.left, cmd_i.right};
    if (stg_re) stg_rdata_q <= stg_mem[stg_raddr];
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[wp_q] <= stg_rdata_q;
    if (ring_re) ring_rdata_q <= ring_mem[rp_q];
  end

  // Result assembly once the ring read data is back
  always_comb begin
    push_data.kind  = iss_q.kind;
    push_data.left  = iss_q.from_mem ? ring_rdata_q[WordW-1:SampleW] : '0;
    push_data.right = iss_q.from_mem ? ring_rdata_q[SampleW-1:0] : '0;
    push_data.drop  = iss_q.drop;
    push_data.last  = iss_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid_q) ofifo_q[owr_q] <= push_data;
  end

  assign head            = ofifo_q[ord_q];
  assign out_valid_o     = (ocnt_q != '0);
  assign kind_o          = head.kind;
  assign out_left_o      = head.left;
  assign out_right_o     = head.right;
  assign dropped_count_o = head.drop;
  assign last_o          = head.last;

  // Checks
  `ARBRC_ASSERT(a_fill_within_size, clk_i, rst_ni,
    (state_q == StIdle && !norm_pend_q) |-> (fill_q <= size))
  `ARBRC_ASSERT(a_ptrs_within_size, clk_i, rst_ni,
    (state_q == StIdle && !norm_pend_q) |-> (SizeW'(rp_q) < size && SizeW'(wp_q) < size))
  `ARBRC_ASSERT_NEVER(a_out_overflow, clk_i, rst_ni,
    iss_valid_q && ocnt_q == OutCntW'(OutDepth) && !out_pop)
  `ARBRC_ASSERT(a_read_packet_len, clk_i, rst_ni,
    (iss_valid_d && iss_d.last && state_q == StRead) |-> (cnt_q == PktCntW'(Packet - 1)))

endmodule

// ===== verif/audio_ring_buffer_overrun_underrun_core_tb.sv =====
`timescale 1ns / 1ps

module audio_ring_buffer_overrun_underrun_core_tb;
  import arbrc_pkg::*;

  // Request codes on action_i
  typedef enum logic {
    ActWrite = 1'b0,
    ActRead  = 1'b1
  } act_e;

  // Result classes on kind_o
  typedef enum logic [1:0] {
    KindSample  = 2'd0,
    KindSilence = 2'd1,
    KindOverrun = 2'd2
  } out_kind_e;

  // Steps of the opening plan
  typedef enum logic [1:0] {
    StepWrite,
    StepRead,
    StepReg
  } step_e;

  typedef struct {
    out_kind_e                 kind;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic [DropW-1:0]          drop;
    logic                      last;
  } fifo_out_t;

  // a/b: samples for writes, register index/value for StepReg.
  // typed rows carry the kind and drop count of every result they cause.
  typedef struct {
    step_e        op;
    logic [31:0]  a;
    logic [31:0]  b;
    int unsigned  reps;
    bit           rnd;
    bit           typed;
    out_kind_e    tk;
    int unsigned  td;
  } plan_row_t;

  typedef struct {
    int unsigned     gap;
    int unsigned     stall;
    logic [CfgW-1:0] cap;
    logic [CfgW-1:0] refill;
  } phase_t;

  // Worst case for the back end to go quiet: a full command queue of commits
  localparam int unsigned DrainCycles = CmdDepth * (Packet + 8) + 16;
  localparam int unsigned QuietLimit  = 20 * DrainCycles;
  localparam int unsigned PhaseItems  = 256;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  act_e                      action_i       = ActWrite;
  logic signed [SampleW-1:0] sample_left_i  = '0;
  logic signed [SampleW-1:0] sample_right_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic [1:0]                kind_o;
  logic signed [SampleW-1:0] out_left_o;
  logic signed [SampleW-1:0] out_right_o;
  logic [DropW-1:0]          dropped_count_o;
  logic                      last_o;
  logic                      cfg_we_i       = 1'b0;
  cfg_reg_e                  cfg_index_i    = RegSize;
  logic [CfgW-1:0]           cfg_wdata_i    = '0;

  audio_ring_buffer_overrun_underrun_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .dropped_count_o(dropped_count_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Idling knobs, percent of cycles
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predicted FIFO state
  logic [63:0]     ring_mem [Depth];
  logic [63:0]     stage_mem [Packet];
  int unsigned     staged     = 0;
  int unsigned     play_ptr   = 0;
  int unsigned     rec_ptr    = 0;
  int unsigned     occupancy  = 0;
  bit              starved    = 1'b0;
  logic [CfgW-1:0] ring_cap_reg   = SizeReset;
  logic [CfgW-1:0] refill_thr_reg = RefillReset;

  fifo_out_t step_out[$];
  fifo_out_t awaited_out[$];

  function automatic int unsigned round_to_packet(input int unsigned x);
    return ((x + Packet - 1) / Packet) * Packet;
  endfunction

  // Usable ring size: packet aligned, clamped to [Packet, Depth]
  function automatic int unsigned ring_span();
    int unsigned s;
    s = (int'(ring_cap_reg) / Packet) * Packet;
    if (s < Packet) s = Packet;
    if (s > Depth) s = Depth;
    return s;
  endfunction

  function automatic fifo_out_t make_out(input out_kind_e k, input logic [31:0] l,
                                         input logic [31:0] r, input int unsigned d,
                                         input logic lst);
    fifo_out_t o;
    o.kind  = k;
    o.left  = l;
    o.right = r;
    o.drop  = DropW'(d);
    o.last  = lst;
    return o;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Apply one accepted request to the predicted state; results go to step_out
  task automatic advance_fifo(input act_e act, input logic [31:0] sl, input logic [31:0] sr);
    int unsigned span, comp, need, to_fill, avail;
    step_out.delete();
    span = ring_span();
    play_ptr = play_ptr % span;
    rec_ptr  = rec_ptr % span;
    if (occupancy > span) occupancy = span;
    if (act == ActWrite) begin
      stage_mem[staged] = {sl, sr};
      staged++;
      if (staged == Packet) begin
        staged = 0;
        // No room for the packet: drop the oldest data first
        if (span - occupancy < Packet) begin
          comp = round_to_packet((span + Packet) / 2);
          need = occupancy - (span - Packet);
          if (comp > span - Packet) comp = span - Packet;
          if (comp < need) comp = need;
          if (comp > occupancy) comp = occupancy;
          occupancy -= comp;
          play_ptr = (play_ptr + comp) % span;
          step_out.push_back(make_out(KindOverrun, '0, '0, comp, 1'b1));
        end
        for (int unsigned i = 0; i < Packet; i++) begin
          ring_mem[rec_ptr] = stage_mem[i];
          rec_ptr = (rec_ptr + 1) % span;
        end
        occupancy += Packet;
      end
    end else begin
      // Underrun handling decides how many buffered samples go out
      if (starved) begin
        to_fill = round_to_packet(refill_thr_reg);
        if (to_fill < Packet) to_fill = Packet;
        if (to_fill > span) to_fill = span;
        if (occupancy < to_fill) begin
          avail = 0;
        end else begin
          starved = 1'b0;
          avail = Packet;
        end
      end else if (occupancy < Packet) begin
        avail = occupancy;
        starved = 1'b1;
      end else begin
        avail = Packet;
      end
      for (int unsigned i = 0; i < Packet; i++) begin
        if (i < avail) begin
          step_out.push_back(make_out(KindSample, ring_mem[play_ptr][63:32],
                                      ring_mem[play_ptr][31:0], 0, i == Packet - 1));
          play_ptr = (play_ptr + 1) % span;
        end else begin
          step_out.push_back(make_out(KindSilence, '0, '0, 0, i == Packet - 1));
        end
      end
      occupancy -= avail;
    end
  endtask

  // Drive one request, hold it until accepted, then queue what it should cause
  task automatic send_request(input act_e act, input logic [31:0] sl, input logic [31:0] sr,
                              input bit typed = 1'b0, input out_kind_e tk = KindSilence,
                              input int unsigned td = 0);
    fifo_out_t due;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    sample_left_i  <= sl;
    sample_right_i <= sr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_fifo(act, sl, sr);
    foreach (step_out[k]) begin
      due = step_out[k];
      if (typed) begin
        due.kind  = tk;
        due.left  = '0;
        due.right = '0;
        due.drop  = DropW'(td);
      end
      awaited_out.push_back(due);
    end
  endtask

  // Stop sending until every queued result has come back
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk_i);
  endtask

  // Drained, plus time for a commit that yields no result to finish
  task automatic settle();
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Assumes the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegSize) ring_cap_reg = val;
    else refill_thr_reg = val;
  endtask

  // Empty the ring before a size change so no unwritten entry is ever read
  task automatic reconfigure(input logic [CfgW-1:0] cap, input logic [CfgW-1:0] refill);
    settle();
    write_reg(RegRefill, CfgW'(Packet));
    while (occupancy != 0) send_request(ActRead, '0, '0);
    settle();
    write_reg(RegSize, cap);
    write_reg(RegRefill, refill);
  endtask

  // Downstream stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Result checker
  always @(posedge clk_i) begin : check_results
    fifo_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_out.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: kind %0d left %0d right %0d drop %0d last %0d",
                 $time, kind_o, out_left_o, out_right_o, dropped_count_o, last_o);
      end else begin
        want = awaited_out.pop_front();
        if (kind_o !== want.kind || out_left_o !== want.left || out_right_o !== want.right ||
            dropped_count_o !== want.drop || last_o !== want.last) begin
          mismatches++;
          $display("%0t: mismatch: expected kind %0d left %0d right %0d drop %0d last %0d",
                   $time, want.kind, want.left, want.right, want.drop, want.last);
          $display("%0t:           actual kind %0d left %0d right %0d drop %0d last %0d",
                   $time, kind_o, out_left_o, out_right_o, dropped_count_o, last_o);
        end
      end
    end
  end

  // Watchdog: too long without any request, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("tb: failure");
      $finish;
    end
  end

  // Opening plan: reset state, sample extremes, freeze, refill, size clamping, overruns
  plan_row_t opening_plan [0:23] = '{
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b1, KindSilence, 0},   // empty after reset
    '{StepWrite, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepWrite, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepWrite, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepWrite, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepWrite, 32'd0, 32'd0, 60, 1'b1, 1'b0, KindSample, 0},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b1, KindSilence, 0},   // frozen below refill
    '{StepReg,   32'(RegRefill), 32'd1, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b0, KindSample, 0},    // leaves freeze
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b1, KindSilence, 0},
    '{StepReg,   32'(RegSize), 32'd100, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepWrite, 32'd0, 32'd0, 64, 1'b1, 1'b0, KindSample, 0},
    '{StepWrite, 32'd0, 32'd0, 64, 1'b1, 1'b1, KindOverrun, 64}, // drop raised to fit
    '{StepReg,   32'(RegRefill), 32'd32767, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b1, KindSilence, 0},
    '{StepReg,   32'(RegSize), 32'd0, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepReg,   32'(RegSize), 32'd32767, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepReg,   32'(RegSize), 32'd128, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepReg,   32'(RegRefill), 32'd64, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepWrite, 32'd0, 32'd0, 192, 1'b1, 1'b1, KindOverrun, 64},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b0, KindSample, 0},
    '{StepRead,  32'd0, 32'd0, 1, 1'b0, 1'b1, KindSilence, 0}
  };

  // Random phases: idling mix and ring setting, extremes included
  phase_t phases [0:4] = '{
    '{0,  0,  CfgW'(64),    CfgW'(64)},
    '{67, 0,  CfgW'(16384), CfgW'(8192)},
    '{0,  67, CfgW'(256),   CfgW'(130)},
    '{26, 26, CfgW'(200),   CfgW'(20)},
    '{0,  0,  CfgW'(128),   CfgW'(16384)}
  };

  initial begin
    plan_row_t   row;
    int unsigned sent;
    int unsigned pick;
    int unsigned n;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    foreach (opening_plan[i]) begin
      row = opening_plan[i];
      if (row.op == StepReg) begin
        settle();
        write_reg(cfg_reg_e'(row.a[0]), row.b[CfgW-1:0]);
      end else begin
        repeat (row.reps)
          send_request((row.op == StepRead) ? ActRead : ActWrite,
                       row.rnd ? pick_sample() : row.a, row.rnd ? pick_sample() : row.b,
                       row.typed, row.tk, row.td);
      end
    end

    // Random part: mostly whole packets and reads, some stray requests
    foreach (phases[p]) begin
      reconfigure(phases[p].cap, phases[p].refill);
      gap_pct   = phases[p].gap;
      stall_pct = phases[p].stall;
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          hold_until_drained();
        end else if (pick < 16) begin
          send_request(act_e'($urandom_range(1)), pick_sample(), pick_sample());
          sent++;
        end else if (pick < 66) begin
          n = Packet - staged;
          repeat (n) send_request(ActWrite, pick_sample(), pick_sample());
          sent += n;
        end else begin
          send_request(ActRead, '0, '0);
          sent++;
        end
      end
    end

    settle();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/arbrc_pkg.sv
hdl/arbrc_front.sv
hdl/arbrc_cmd_fifo.sv
hdl/arbrc_back.sv
hdl/audio_ring_buffer_overrun_underrun_core.sv
verif/audio_ring_buffer_overrun_underrun_core_tb.sv
